@@ rtl/mlp_sigmoid_train_infer_assert.svh @@
// Assertion macros shared by the design. The enclosing module supplies clk and rst.
`ifndef MLP_SIGMOID_TRAIN_INFER_ASSERT_SVH
`define MLP_SIGMOID_TRAIN_INFER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLPST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLPST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mlpst_pkg.sv @@
package mlpst_pkg;

  localparam int DEF_INPUT_FEATURES = 4;
  localparam int DEF_HIDDEN_UNITS   = 5;
  localparam int DEF_OUTPUT_CLASSES = 3;
  localparam int PORT_FEATURES      = 4;
  localparam int PORT_SCORES        = 3;

  localparam logic [15:0] LR_RESET = 16'd6554;
  localparam int WADDR_W = 7;

  localparam int SIG_ENTRIES = 33;
  localparam logic [15:0] SIG_TABLE [SIG_ENTRIES] = '{
    16'd22, 16'd36, 16'd60, 16'd98, 16'd162, 16'd267, 16'd439, 16'd720,
    16'd1179, 16'd1921, 16'd3108, 16'd4971, 16'd7812, 16'd11955, 16'd17625,
    16'd24743, 16'd32768, 16'd40793, 16'd47911, 16'd53581, 16'd57724,
    16'd60565, 16'd62428, 16'd63615, 16'd64357, 16'd64816, 16'd65097,
    16'd65269, 16'd65374, 16'd65438, 16'd65476, 16'd65500, 16'd65514
  };

  typedef enum logic [1:0] {
    CMD_INFER = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic [1:0]         target_class;
    logic [6:0]         weight_index;
    logic signed [23:0] weight_value;
  } item_t;

  typedef struct packed {
    logic [15:0]        score_0;
    logic [15:0]        score_1;
    logic [15:0]        score_2;
    logic [1:0]         predicted_class;
    logic               prediction_correct;
    logic [16:0]        sample_cost;
    logic signed [23:0] weight_read_value;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] addr;
    logic signed [23:0] wdata;
  } mem_req_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_WRITE, ST_READ_A, ST_READ_B,
    ST_F1_RD, ST_F1_MUL, ST_F1_ACC, ST_F1_BRD, ST_F1_Z,
    ST_F2_RD, ST_F2_MUL, ST_F2_ACC, ST_F2_BRD, ST_F2_Z,
    ST_SIG1, ST_SIG2, ST_SIG3, ST_ARGMAX,
    ST_COST_MUL, ST_COST_ACC, ST_COST_FIN,
    ST_B_RD, ST_B_MUL, ST_B_ACC, ST_B_S, ST_B_D, ST_B_D1MUL, ST_B_D1,
    ST_U_RD, ST_U_MUL, ST_U_RND, ST_U_WR, ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RG_W2, RG_B2, RG_W1, RG_B1
  } region_t;

endpackage

@@ rtl/mlpst_wmem.sv @@
module mlpst_wmem import mlpst_pkg::*; #(
  parameter int DEPTH = 43
) (
  input  logic               clk,
  input  logic               rst,
  input  mem_req_t           req,
  output logic signed [23:0] rdata
);

  localparam int AW = $clog2(DEPTH);

  logic signed [23:0] mem [DEPTH];
  logic [DEPTH-1:0]   valid;
  logic [AW-1:0]      a;

  assign a = req.addr[AW-1:0];

  // Words never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.we) begin
      valid[a] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[a] <= req.wdata;
    end
    rdata <= valid[a] ? mem[a] : '0;
  end

endmodule

@@ rtl/mlpst_sigmoid.sv @@
module mlpst_sigmoid import mlpst_pkg::*; (
  input  logic               clk,
  input  logic signed [31:0] z,
  output logic [15:0]        y
);

  logic signed [31:0] zc;
  logic [31:0]        u;
  logic [5:0]         idx;
  logic [14:0]        frac;
  logic [5:0]         hi_idx;
  logic [15:0]        lo;
  logic [15:0]        hi;
  logic [31:0]        interp;

  always_comb begin
    if (z > 32'sd524288) begin
      zc = 32'sd524288;
    end else if (z < -32'sd524288) begin
      zc = -32'sd524288;
    end else begin
      zc = z;
    end
    u = 32'(zc + 32'sd524288);
  end

  always_ff @(posedge clk) begin
    idx  <= u[20:15];
    frac <= u[14:0];
  end

  // The top sample point has no right neighbor and is returned as is.
  always_comb begin
    hi_idx = (idx >= 6'd32) ? 6'd32 : idx + 6'd1;
    lo     = SIG_TABLE[idx];
    hi     = SIG_TABLE[hi_idx];
    interp = 32'(hi - lo) * {17'd0, frac} + 32'd16384;
  end

  always_ff @(posedge clk) begin
    if (idx >= 6'd32) begin
      y <= SIG_TABLE[32];
    end else begin
      y <= lo + interp[30:15];
    end
  end

endmodule

@@ rtl/mlpst_core.sv @@
`include "mlp_sigmoid_train_infer_assert.svh"

module mlpst_core import mlpst_pkg::*; #(
  parameter int INPUT_FEATURES = DEF_INPUT_FEATURES,
  parameter int HIDDEN_UNITS   = DEF_HIDDEN_UNITS,
  parameter int OUTPUT_CLASSES = DEF_OUTPUT_CLASSES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  item_t              item,
  output logic               idle,
  input  logic [15:0]        learn_rate,
  output mem_req_t           mem_req,
  input  logic signed [23:0] mem_rdata,
  output logic signed [31:0] sig_z,
  input  logic [15:0]        sig_y,
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res
);

  localparam int IW = (INPUT_FEATURES > 1) ? $clog2(INPUT_FEATURES) : 1;
  localparam int HW = (HIDDEN_UNITS > 1) ? $clog2(HIDDEN_UNITS) : 1;
  localparam int OW = (OUTPUT_CLASSES > 1) ? $clog2(OUTPUT_CLASSES) : 1;

  localparam logic [WADDR_W-1:0] B1_A = WADDR_W'(INPUT_FEATURES * HIDDEN_UNITS);
  localparam logic [WADDR_W-1:0] W2_A = WADDR_W'(INPUT_FEATURES * HIDDEN_UNITS + HIDDEN_UNITS);
  localparam logic [WADDR_W-1:0] B2_A =
    WADDR_W'(INPUT_FEATURES * HIDDEN_UNITS + HIDDEN_UNITS + HIDDEN_UNITS * OUTPUT_CLASSES);
  localparam logic [WADDR_W-1:0] STORE_A = WADDR_W'(INPUT_FEATURES * HIDDEN_UNITS +
    HIDDEN_UNITS + HIDDEN_UNITS * OUTPUT_CLASSES + OUTPUT_CLASSES);

  localparam logic [IW-1:0] I_LAST = IW'(INPUT_FEATURES - 1);
  localparam logic [HW-1:0] H_LAST = HW'(HIDDEN_UNITS - 1);
  localparam logic [OW-1:0] O_LAST = OW'(OUTPUT_CLASSES - 1);

  function automatic logic signed [63:0] rnd(input logic signed [63:0] v,
                                             input int unsigned n);
    logic signed [63:0] half;
    half = 64'sd1 <<< (n - 1);
    return (v + half) >>> n;
  endfunction

  state_t state, state_next;
  region_t region;
  logic l2;

  logic [1:0]               cmd;
  logic [1:0]               tgt;
  logic [6:0]               widx;
  logic signed [23:0]       wval;
  logic signed [15:0]       x [INPUT_FEATURES];
  logic signed [15:0]       feat [PORT_FEATURES];

  logic [IW-1:0]            icnt;
  logic [HW-1:0]            hcnt;
  logic [OW-1:0]            ocnt;
  logic [WADDR_W-1:0]       addr;

  logic signed [63:0]       acc;
  logic signed [61:0]       prod;
  logic signed [63:0]       prod_ext;
  logic signed [33:0]       mul_a;
  logic signed [27:0]       mul_b;

  logic [15:0]              a1 [HIDDEN_UNITS];
  logic signed [27:0]       d1 [HIDDEN_UNITS];
  logic [15:0]              a2 [OUTPUT_CLASSES];
  logic signed [17:0]       d2 [OUTPUT_CLASSES];
  logic signed [27:0]       sreg;
  logic [14:0]              dreg;
  logic signed [23:0]       wold;
  logic signed [33:0]       delta;
  logic signed [34:0]       wdiff;
  logic signed [23:0]       wnew;
  logic signed [31:0]       zreg;

  logic [1:0]               pred;
  logic                     correct;
  logic [16:0]              cost;
  logic signed [23:0]       rdval;
  logic [1:0]               pred_c;
  logic [15:0]              best_c;
  logic [15:0]              score_pad [PORT_SCORES];
  logic                     in_beat;

  assign in_beat  = item_valid && (state == ST_IDLE);
  assign prod_ext = {{2{prod[61]}}, prod};
  assign sig_z    = zreg;

  assign feat[0] = item.feature_0;
  assign feat[1] = item.feature_1;
  assign feat[2] = item.feature_2;
  assign feat[3] = item.feature_3;

  always_comb begin
    pred_c = 2'd0;
    best_c = a2[0];
    for (int o = 1; o < OUTPUT_CLASSES; o++) begin
      if (a2[o] > best_c) begin
        best_c = a2[o];
        pred_c = 2'(o);
      end
    end
  end

  always_comb begin
    wdiff = 35'(wold) - 35'(delta);
    if (wdiff > 35'sd8388607) begin
      wnew = 24'sh7FFFFF;
    end else if (wdiff < -35'sd8388608) begin
      wnew = -24'sd8388608;
    end else begin
      wnew = wdiff[23:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.command)
            CMD_WRITE: state_next = ST_WRITE;
            CMD_READ:  state_next = ST_READ_A;
            default:   state_next = ST_F1_RD;
          endcase
        end
      end
      ST_WRITE:    state_next = ST_DONE;
      ST_READ_A:   state_next = ST_READ_B;
      ST_READ_B:   state_next = ST_DONE;
      ST_F1_RD:    state_next = ST_F1_MUL;
      ST_F1_MUL:   state_next = ST_F1_ACC;
      ST_F1_ACC:   state_next = (icnt == I_LAST) ? ST_F1_BRD : ST_F1_RD;
      ST_F1_BRD:   state_next = ST_F1_Z;
      ST_F1_Z:     state_next = ST_SIG1;
      ST_F2_RD:    state_next = ST_F2_MUL;
      ST_F2_MUL:   state_next = ST_F2_ACC;
      ST_F2_ACC:   state_next = (hcnt == H_LAST) ? ST_F2_BRD : ST_F2_RD;
      ST_F2_BRD:   state_next = ST_F2_Z;
      ST_F2_Z:     state_next = ST_SIG1;
      ST_SIG1:     state_next = ST_SIG2;
      ST_SIG2:     state_next = ST_SIG3;
      ST_SIG3: begin
        if (!l2) begin
          state_next = (hcnt == H_LAST) ? ST_F2_RD : ST_F1_RD;
        end else begin
          state_next = (ocnt == O_LAST) ? ST_ARGMAX : ST_F2_RD;
        end
      end
      ST_ARGMAX:   state_next = (cmd == CMD_TRAIN) ? ST_COST_MUL : ST_DONE;
      ST_COST_MUL: state_next = ST_COST_ACC;
      ST_COST_ACC: state_next = (ocnt == O_LAST) ? ST_COST_FIN : ST_COST_MUL;
      ST_COST_FIN: state_next = ST_B_RD;
      ST_B_RD:     state_next = ST_B_MUL;
      ST_B_MUL:    state_next = ST_B_ACC;
      ST_B_ACC:    state_next = (ocnt == O_LAST) ? ST_B_S : ST_B_RD;
      ST_B_S:      state_next = ST_B_D;
      ST_B_D:      state_next = ST_B_D1MUL;
      ST_B_D1MUL:  state_next = ST_B_D1;
      ST_B_D1:     state_next = (hcnt == H_LAST) ? ST_U_RD : ST_B_RD;
      ST_U_RD:     state_next = ST_U_MUL;
      ST_U_MUL:    state_next = ST_U_RND;
      ST_U_RND:    state_next = ST_U_WR;
      ST_U_WR: begin
        state_next = (region == RG_B1 && hcnt == H_LAST) ? ST_DONE : ST_U_RD;
      end
      ST_DONE:     state_next = res_take ? ST_IDLE : ST_DONE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port, multiplier operands, result beat.
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = addr;
    mem_req.wdata = wnew;
    mul_a         = '0;
    mul_b         = '0;
    idle          = (state == ST_IDLE);
    res_valid     = (state == ST_DONE);
    case (state)
      ST_WRITE: begin
        mem_req.we    = (widx < STORE_A);
        mem_req.addr  = widx;
        mem_req.wdata = wval;
      end
      ST_READ_A: mem_req.addr = widx;
      ST_F1_MUL: begin
        mul_a = 34'(x[icnt]);
        mul_b = 28'(mem_rdata);
      end
      ST_F2_MUL: begin
        mul_a = {18'd0, a1[hcnt]};
        mul_b = 28'(mem_rdata);
      end
      ST_COST_MUL: begin
        mul_a = 34'(d2[ocnt]);
        mul_b = 28'(d2[ocnt]);
      end
      ST_B_MUL: begin
        mul_a = 34'(d2[ocnt]);
        mul_b = 28'(mem_rdata);
      end
      ST_B_S: begin
        mul_a = {18'd0, a1[hcnt]};
        mul_b = {11'd0, 17'h10000 - {1'b0, a1[hcnt]}};
      end
      ST_B_D1MUL: begin
        mul_a = 34'(sreg);
        mul_b = {13'd0, dreg};
      end
      ST_U_RD: begin
        mul_a = {18'd0, learn_rate};
        case (region)
          RG_W2:   mul_b = {12'd0, a1[hcnt]};
          RG_W1:   mul_b = 28'(x[icnt]);
          default: mul_b = 28'sd1;
        endcase
      end
      ST_U_MUL: begin
        mul_a = prod[33:0];
        case (region)
          RG_W2, RG_B2: mul_b = 28'(d2[ocnt]);
          default:      mul_b = d1[hcnt];
        endcase
      end
      ST_U_WR: mem_req.we = 1'b1;
      default: ;
    endcase

    for (int k = 0; k < PORT_SCORES; k++) begin
      score_pad[k] = '0;
    end
    for (int k = 0; k < OUTPUT_CLASSES; k++) begin
      score_pad[k] = a2[k];
    end

    res = '0;
    if (cmd == CMD_INFER || cmd == CMD_TRAIN) begin
      res.score_0            = score_pad[0];
      res.score_1            = score_pad[1];
      res.score_2            = score_pad[2];
      res.predicted_class    = pred;
      res.prediction_correct = correct;
    end
    res.sample_cost       = cost;
    res.weight_read_value = rdval;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      region <= RG_W2;
      l2     <= 1'b0;
      icnt   <= '0;
      hcnt   <= '0;
      ocnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            l2   <= 1'b0;
            icnt <= '0;
            hcnt <= '0;
            ocnt <= '0;
          end
        end
        ST_F1_ACC: begin
          if (icnt != I_LAST) begin
            icnt <= icnt + 1'b1;
          end
        end
        ST_F2_ACC, ST_B_ACC: begin
          if (state == ST_F2_ACC && hcnt != H_LAST) begin
            hcnt <= hcnt + 1'b1;
          end
          if (state == ST_B_ACC && ocnt != O_LAST) begin
            ocnt <= ocnt + 1'b1;
          end
        end
        ST_SIG3: begin
          if (!l2) begin
            icnt <= '0;
            if (hcnt == H_LAST) begin
              hcnt <= '0;
              ocnt <= '0;
              l2   <= 1'b1;
            end else begin
              hcnt <= hcnt + 1'b1;
            end
          end else begin
            hcnt <= '0;
            if (ocnt != O_LAST) begin
              ocnt <= ocnt + 1'b1;
            end
          end
        end
        ST_ARGMAX: ocnt <= '0;
        ST_COST_ACC: begin
          if (ocnt != O_LAST) begin
            ocnt <= ocnt + 1'b1;
          end
        end
        ST_COST_FIN: begin
          hcnt <= '0;
          ocnt <= '0;
        end
        ST_B_D1: begin
          ocnt <= '0;
          if (hcnt == H_LAST) begin
            hcnt   <= '0;
            region <= RG_W2;
          end else begin
            hcnt <= hcnt + 1'b1;
          end
        end
        ST_U_WR: begin
          case (region)
            RG_W2: begin
              if (ocnt == O_LAST) begin
                ocnt <= '0;
                if (hcnt == H_LAST) begin
                  hcnt   <= '0;
                  region <= RG_B2;
                end else begin
                  hcnt <= hcnt + 1'b1;
                end
              end else begin
                ocnt <= ocnt + 1'b1;
              end
            end
            RG_B2: begin
              if (ocnt == O_LAST) begin
                ocnt   <= '0;
                icnt   <= '0;
                hcnt   <= '0;
                region <= RG_W1;
              end else begin
                ocnt <= ocnt + 1'b1;
              end
            end
            RG_W1: begin
              if (hcnt == H_LAST) begin
                hcnt <= '0;
                if (icnt == I_LAST) begin
                  region <= RG_B1;
                end else begin
                  icnt <= icnt + 1'b1;
                end
              end else begin
                hcnt <= hcnt + 1'b1;
              end
            end
            default: begin
              if (hcnt != H_LAST) begin
                hcnt <= hcnt + 1'b1;
              end
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (in_beat) begin
          cmd   <= item.command;
          tgt   <= item.target_class;
          widx  <= item.weight_index;
          wval  <= item.weight_value;
          for (int i = 0; i < INPUT_FEATURES; i++) begin
            x[i] <= feat[i];
          end
          addr  <= '0;
          acc   <= '0;
          cost  <= '0;
          rdval <= '0;
        end
      end
      ST_READ_B: rdval <= (widx < STORE_A) ? mem_rdata : '0;
      ST_F1_ACC: begin
        acc <= acc + prod_ext;
        if (icnt == I_LAST) begin
          addr <= B1_A + WADDR_W'(hcnt);
        end else begin
          addr <= addr + WADDR_W'(HIDDEN_UNITS);
        end
      end
      ST_F1_Z: zreg <= 32'(rnd(acc, 12) + 64'(mem_rdata));
      ST_F2_ACC: begin
        acc <= acc + prod_ext;
        if (hcnt == H_LAST) begin
          addr <= B2_A + WADDR_W'(ocnt);
        end else begin
          addr <= addr + WADDR_W'(OUTPUT_CLASSES);
        end
      end
      ST_F2_Z: zreg <= 32'(rnd(acc, 16) + 64'(mem_rdata));
      ST_SIG3: begin
        acc <= '0;
        if (!l2) begin
          a1[hcnt] <= sig_y;
          if (hcnt == H_LAST) begin
            addr <= W2_A;
          end else begin
            addr <= WADDR_W'(hcnt) + WADDR_W'(1);
          end
        end else begin
          a2[ocnt] <= sig_y;
          addr     <= W2_A + WADDR_W'(ocnt) + WADDR_W'(1);
        end
      end
      ST_ARGMAX: begin
        pred    <= pred_c;
        correct <= (pred_c == tgt);
        acc     <= '0;
        for (int o = 0; o < OUTPUT_CLASSES; o++) begin
          d2[o] <= 18'({2'b00, a2[o]}) - ((2'(o) == tgt) ? 18'sd65536 : 18'sd0);
        end
      end
      ST_COST_ACC: acc <= acc + prod_ext;
      ST_COST_FIN: begin
        cost <= 17'(rnd(acc, 17));
        acc  <= '0;
        addr <= W2_A;
      end
      ST_B_ACC: begin
        acc  <= acc + prod_ext;
        addr <= addr + WADDR_W'(1);
      end
      ST_B_S: sreg <= 28'(rnd(acc, 16));
      ST_B_D: dreg <= 15'(rnd(prod_ext, 16));
      ST_B_D1: begin
        d1[hcnt] <= 28'(rnd(prod_ext, 16));
        acc      <= '0;
        if (hcnt == H_LAST) begin
          addr <= W2_A;
        end
      end
      ST_U_MUL: wold <= mem_rdata;
      ST_U_RND: begin
        case (region)
          RG_W2:   delta <= 34'(rnd(prod_ext, 32));
          RG_W1:   delta <= 34'(rnd(prod_ext, 28));
          default: delta <= 34'(rnd(prod_ext, 16));
        endcase
      end
      ST_U_WR: begin
        // Output biases are followed by W1 at the start of the store.
        if (region == RG_B2 && ocnt == O_LAST) begin
          addr <= '0;
        end else begin
          addr <= addr + WADDR_W'(1);
        end
      end
      default: ;
    endcase
  end

  `MLPST_ASSERT_NOW(a_we_states, mem_req.we, (state == ST_WRITE) || (state == ST_U_WR), "store written outside a write step")
  `MLPST_ASSERT_NOW(a_we_range, mem_req.we, mem_req.addr < STORE_A, "store write beyond last word")
  `MLPST_ASSERT_NEXT(a_done_hold, (state == ST_DONE) && !res_take, state == ST_DONE, "result dropped before it was taken")
  `MLPST_ASSERT_NOW(a_hcnt_range, state != ST_IDLE, hcnt <= H_LAST, "hidden unit counter out of range")

endmodule

@@ rtl/mlp_sigmoid_train_infer.sv @@
// Two-layer sigmoid perceptron with on-chip training.
// Items enter on the item channel (item_valid/item_ready) and one result beat
// per item leaves on the result channel (result_valid/result_ready).
// Commands: infer gives scores, argmax class and match flag; train gives the
// same plus the half squared error, then updates every weight in place;
// write and read move one word of the weight store.
// One item is worked on at a time through one shared multiplier and a
// single-port weight memory. The result sits in an output register, so a
// stalled receiver does not stop the next item from being accepted; that
// item finishes its work and then waits until the register frees up.
// learn_rate is written through cfg_we and cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// Reset clears the weight store to zero, sets learn_rate to 6554 and
// empties the output register.
module mlp_sigmoid_train_infer import mlpst_pkg::*; #(
  parameter int INPUT_FEATURES = DEF_INPUT_FEATURES,
  parameter int HIDDEN_UNITS   = DEF_HIDDEN_UNITS,
  parameter int OUTPUT_CLASSES = DEF_OUTPUT_CLASSES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result
);

  localparam int STORE_WORDS = INPUT_FEATURES * HIDDEN_UNITS + HIDDEN_UNITS +
                               HIDDEN_UNITS * OUTPUT_CLASSES + OUTPUT_CLASSES;

  logic [15:0]        learn_rate;
  mem_req_t           mem_req;
  logic signed [23:0] mem_rdata;
  logic signed [31:0] sig_z;
  logic [15:0]        sig_y;
  logic               idle;
  logic               res_valid;
  logic               res_take;
  result_t            res;

  always_ff @(posedge clk) begin
    if (rst) begin
      learn_rate <= LR_RESET;
    end else if (cfg_we) begin
      learn_rate <= cfg_data;
    end
  end

  assign item_ready = idle;
  assign res_take   = res_valid && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_take) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      result <= res;
    end
  end

  mlpst_wmem #(
    .DEPTH(STORE_WORDS)
  ) u_wmem (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  mlpst_sigmoid u_sigmoid (
    .clk (clk),
    .z   (sig_z),
    .y   (sig_y)
  );

  mlpst_core #(
    .INPUT_FEATURES (INPUT_FEATURES),
    .HIDDEN_UNITS   (HIDDEN_UNITS),
    .OUTPUT_CLASSES (OUTPUT_CLASSES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .idle       (idle),
    .learn_rate (learn_rate),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .sig_z      (sig_z),
    .sig_y      (sig_y),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

endmodule

@@ tb/mlp_sigmoid_train_infer_checker.sv @@
`timescale 1ns / 1ps
module mlp_sigmoid_train_infer_checker import mlpst_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    cfg_we,
  input  logic [15:0] cfg_data,
  input  logic    item_valid,
  input  logic    item_ready,
  input  item_t   item,
  input  logic    result_valid,
  input  logic    result_ready,
  input  result_t result,
  output int      fail_count,
  output int      pending
);
  localparam int NI = 4;
  localparam int NH = 5;
  localparam int NO = 3;
  localparam int B1B = NI * NH;
  localparam int W2B = B1B + NH;
  localparam int B2B = W2B + NH * NO;
  localparam int WORDS = B2B + NO;

  longint net_weights [WORDS];
  longint step_size;
  result_t expected_results [$];

  function automatic longint rnd_shift(longint v, int n);
    longint w;
    w = v + (longint'(1) << (n - 1));
    // Arithmetic shift floors, which matches half-up rounding after the bias.
    return w >>> n;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic longint squash(longint z);
    longint u, idx, frac, lo, hi;
    if (z > 524288) z = 524288;
    if (z < -524288) z = -524288;
    u = z + 524288;
    idx = u >> 15;
    frac = u & 32767;
    if (idx >= 32) return SIG_TABLE[32];
    lo = SIG_TABLE[idx];
    hi = SIG_TABLE[idx + 1];
    return lo + (((hi - lo) * frac + 16384) >> 15);
  endfunction

  function automatic result_t evaluate(item_t it);
    result_t r;
    longint x [NI];
    longint a1 [NH];
    longint a2 [NO];
    longint d2 [NO];
    longint d1 [NH];
    longint acc, best, s, d;
    int pred, k;
    r = '0;
    if (it.command == CMD_WRITE) begin
      if (it.weight_index < WORDS) net_weights[it.weight_index] = it.weight_value;
      return r;
    end
    if (it.command == CMD_READ) begin
      if (it.weight_index < WORDS) r.weight_read_value = net_weights[it.weight_index];
      return r;
    end
    x[0] = it.feature_0; x[1] = it.feature_1; x[2] = it.feature_2; x[3] = it.feature_3;
    for (int h = 0; h < NH; h++) begin
      acc = 0;
      for (int i = 0; i < NI; i++) acc += x[i] * net_weights[i * NH + h];
      a1[h] = squash(rnd_shift(acc, 12) + net_weights[B1B + h]);
    end
    for (int o = 0; o < NO; o++) begin
      acc = 0;
      for (int h = 0; h < NH; h++) acc += a1[h] * net_weights[W2B + h * NO + o];
      a2[o] = squash(rnd_shift(acc, 16) + net_weights[B2B + o]);
    end
    r.score_0 = a2[0]; r.score_1 = a2[1]; r.score_2 = a2[2];
    pred = 0;
    best = a2[0];
    for (int o = 1; o < NO; o++) if (a2[o] > best) begin
      best = a2[o];
      pred = o;
    end
    r.predicted_class = pred;
    r.prediction_correct = (pred == it.target_class);
    if (it.command != CMD_TRAIN) return r;
    acc = 0;
    for (int o = 0; o < NO; o++) begin
      d2[o] = a2[o] - ((o == it.target_class) ? 65536 : 0);
      acc += d2[o] * d2[o];
    end
    r.sample_cost = rnd_shift(acc, 17);
    for (int h = 0; h < NH; h++) begin
      acc = 0;
      for (int o = 0; o < NO; o++) acc += d2[o] * net_weights[W2B + h * NO + o];
      s = rnd_shift(acc, 16);
      d = rnd_shift(a1[h] * (65536 - a1[h]), 16);
      d1[h] = rnd_shift(s * d, 16);
    end
    for (int h = 0; h < NH; h++)
      for (int o = 0; o < NO; o++) begin
        k = W2B + h * NO + o;
        net_weights[k] = clip24(net_weights[k] - rnd_shift(step_size * a1[h] * d2[o], 32));
      end
    for (int o = 0; o < NO; o++)
      net_weights[B2B + o] = clip24(net_weights[B2B + o] - rnd_shift(step_size * d2[o], 16));
    for (int i = 0; i < NI; i++)
      for (int h = 0; h < NH; h++) begin
        k = i * NH + h;
        net_weights[k] = clip24(net_weights[k] - rnd_shift(step_size * x[i] * d1[h], 28));
      end
    for (int h = 0; h < NH; h++)
      net_weights[B1B + h] = clip24(net_weights[B1B + h] - rnd_shift(step_size * d1[h], 16));
    return r;
  endfunction

  assign pending = expected_results.size();

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      foreach (net_weights[k]) net_weights[k] = 0;
      step_size = LR_RESET;
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) step_size = cfg_data;
      if (item_valid && item_ready) expected_results.push_back(evaluate(item));
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.score_0 !== want.score_0) begin
            $error("score_0 exp %0d got %0d", want.score_0, result.score_0); fail_count++;
          end
          if (result.score_1 !== want.score_1) begin
            $error("score_1 exp %0d got %0d", want.score_1, result.score_1); fail_count++;
          end
          if (result.score_2 !== want.score_2) begin
            $error("score_2 exp %0d got %0d", want.score_2, result.score_2); fail_count++;
          end
          if (result.predicted_class !== want.predicted_class) begin
            $error("predicted_class exp %0d got %0d", want.predicted_class,
                   result.predicted_class); fail_count++;
          end
          if (result.prediction_correct !== want.prediction_correct) begin
            $error("prediction_correct exp %0d got %0d", want.prediction_correct,
                   result.prediction_correct); fail_count++;
          end
          if (result.sample_cost !== want.sample_cost) begin
            $error("sample_cost exp %0d got %0d", want.sample_cost, result.sample_cost);
            fail_count++;
          end
          if (result.weight_read_value !== want.weight_read_value) begin
            $error("weight_read_value exp %0d got %0d", want.weight_read_value,
                   result.weight_read_value); fail_count++;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb_mlp_sigmoid_train_infer.sv @@
`timescale 1ns / 1ps
module tb_mlp_sigmoid_train_infer;
  import mlpst_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  int recv_wait = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  mlp_sigmoid_train_infer u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result)
  );

  mlp_sigmoid_train_infer_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .fail_count(fail_count), .pending(pending)
  );

  // Receiver: draw a wait per result beat, then hold ready until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      recv_wait <= $urandom_range(0, 17);
    end else if (result_ready && result_valid) begin
      recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      result_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Valid stays high across back-to-back beats and drops only before a gap.
  task automatic send(item_t it, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_rate(logic [15:0] v);
    drain();
    cfg_data <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t rand_item(int mode);
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom, $urandom});
    case (mode)
      0: it.command = $urandom_range(0, 3);
      1: it.command = ($urandom_range(0, 2) == 0) ? CMD_INFER : CMD_TRAIN;
      default: it.command = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
    endcase
    if ($urandom_range(0, 9) != 0) it.weight_index = $urandom_range(0, 42);
    if ($urandom_range(0, 9) != 0) it.target_class = $urandom_range(0, 2);
    // Mostly modest features and weights so training stays out of saturation.
    if ($urandom_range(0, 3) != 0) begin
      it.feature_0 = $signed($urandom_range(0, 16383)) - 8192;
      it.feature_1 = $signed($urandom_range(0, 16383)) - 8192;
      it.feature_2 = $signed($urandom_range(0, 16383)) - 8192;
      it.feature_3 = $signed($urandom_range(0, 16383)) - 8192;
      it.weight_value = $signed($urandom_range(0, 262143)) - 131072;
    end
    return it;
  endfunction

  initial begin
    item_t it;
    logic [15:0] rates [4];
    rates = '{16'd0, 16'd65535, 16'd6554, 16'd20000};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero network, write extremes, read back, out-of-range address, training on extreme features.
    it = '0; it.command = CMD_INFER; send(it, 1'b1);
    it.command = CMD_TRAIN; it.target_class = 2'd3; send(it, 1'b0);
    it = '0; it.command = CMD_WRITE; it.weight_index = 7'd0;
    it.weight_value = 24'sh7FFFFF; send(it, 1'b0);
    it.weight_index = 7'd42; it.weight_value = 24'sh800000; send(it, 1'b0);
    it.weight_index = 7'd127; it.weight_value = 24'sh123456; send(it, 1'b0);
    it.command = CMD_READ; it.weight_index = 7'd0; send(it, 1'b0);
    it.weight_index = 7'd42; send(it, 1'b0);
    it.weight_index = 7'd127; send(it, 1'b0);
    it = '0; it.command = CMD_TRAIN; it.feature_0 = 16'sh7FFF; it.feature_1 = 16'sh8000;
    it.feature_2 = 16'sh7FFF; it.feature_3 = 16'sh8000; it.target_class = 2'd0;
    send(it, 1'b0);
    it.target_class = 2'd1; send(it, 1'b0);
    it.target_class = 2'd2; it.command = CMD_INFER; send(it, 1'b0);
    it.feature_0 = '1; it.feature_1 = '1; it.feature_2 = '1; it.feature_3 = '1;
    it.command = CMD_TRAIN; send(it, 1'b0);
    set_rate(16'd65535);

    for (int p = 0; p < 4; p++) begin
      if (p > 0) set_rate(rates[p]);
      for (int n = 0; n < 100; n++) begin
        int mode;
        mode = (n % 25 == 0) ? 2 : ($urandom_range(0, 4) == 0 ? 0 : 1);
        send(rand_item(mode), $urandom_range(0, 4) == 0);
        if (n == 50) drain();
      end
    end

    drain();
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
